/* rtl/assert_macros.svh */
// Assertion macros used by the port-level checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Concurrent assertion clocked on rising clk, off while reset is low
`define CHK_ASSERT(label, clk_s, rstn_s, prop, msg) \
    label: assert property (@(posedge clk_s) disable iff (!rstn_s) (prop)) else $error(msg);
`endif

/* rtl/mlce_pkg.sv */
// Shared types and constants of the midpoint rasteriser
`default_nettype none
package mlce_pkg;
    localparam int COORD_BITS  = 12;
    localparam int RADIUS_BITS = 10;
    localparam int PT_BITS     = COORD_BITS + 1;
    localparam int DEC_BITS    = 48;
    localparam int SQ_BITS     = 2 * RADIUS_BITS;
    localparam int IN_BITS     = 2 * RADIUS_BITS + 4 * COORD_BITS + 2;
    localparam int IN_BYTES    = (IN_BITS + 7) / 8;
    localparam int OUT_BITS    = 2 * PT_BITS + DEC_BITS;
    localparam int OUT_BYTES   = (OUT_BITS + 7) / 8;

    localparam logic [1:0] MODE_LINE    = 2'd0;
    localparam logic [1:0] MODE_CIRCLE  = 2'd1;
    localparam logic [1:0] MODE_ELLIPSE = 2'd2;
    localparam logic [1:0] MODE_UNUSED  = 2'd3;
    localparam logic       CMD_START    = 1'b0;
    localparam logic       CMD_NEXT     = 1'b1;

    // Multiplier operation request from the sequencer
    typedef struct packed {
        logic [DEC_BITS-1:0] a;
        logic [DEC_BITS-1:0] b;
    } mul_req_t;
endpackage
`default_nettype wire

/* rtl/mlce_mul.sv */
// Shared registered multiplier, 25 by 24 bits, for products of the sequencer
`default_nettype none
module mlce_mul (
    input  wire logic                          clk,
    input  wire mlce_pkg::mul_req_t            req,
    output logic [mlce_pkg::DEC_BITS-1:0]      prod
);
    import mlce_pkg::*;
    logic [DEC_BITS-1:0] prod_reg;
    // Register the low bits of one product a cycle (modulo 2^48)
    always_ff @(posedge clk)
    begin
        prod_reg <= DEC_BITS'(req.a[24:0] * req.b[23:0]);
    end
    assign prod = prod_reg;
endmodule
`default_nettype wire

/* rtl/midpoint_line_circle_ellipse_raster.sv */
// Midpoint line, circle and ellipse quadrant rasteriser, top level
// Usage:
//  s_axis carries commands: tuser = command (0 start, 1 next point); tdata
//  holds shape_mode, start_x, start_y, end_x, end_y, radius_x, radius_y.
//  A start loads a primitive and gives no word. A next command gives one word
//  on m_axis: point_x, point_y, decision; tlast marks the final point.
//  A next while idle gives nothing.
// Sequencing:
//  line, circle and unused-code starts stay in S_IDLE; ellipse starts pass S_E1 to S_E3.
//  A line, circle or ellipse-end point passes S_STEP and S_OUT to reach m_axis;
//  an ellipse point also passes S_R1 and S_R2, and S_R3 to S_R5, S_E4 and S_E5 when it
//  crosses into region two. The next command is taken once the word has been taken.
//  Products come from one shared registered multiplier, one product a cycle.
// Reset clears the sequencer and the output valid; no word is pending.
// When the receiver stalls, the result word waits in the output register and
// s_tready stays low until it is taken.
`default_nettype none
module midpoint_line_circle_ellipse_raster (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    // shape_mode, start_x, start_y, end_x, end_y, radius_x, radius_y
    input  wire logic [mlce_pkg::IN_BYTES*8-1:0]   s_tdata,
    // command
    input  wire logic                              s_tuser,
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    // point_x, point_y, decision
    output logic [mlce_pkg::OUT_BYTES*8-1:0]       m_tdata,
    output logic                                   m_tlast
);
    import mlce_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_STEP, S_E1, S_E2, S_E3, S_E4, S_E5,
        S_R1, S_R2, S_R3, S_R4, S_R5, S_OUT
    } state_t;

    localparam int D = DEC_BITS;

    state_t state_reg, state_next;
    logic               act_reg, act_next;
    logic [1:0]         mode_reg, mode_next;
    logic               r2_reg, r2_next;
    logic [PT_BITS-1:0] cx_reg, cx_next, cy_reg, cy_next;
    logic [COORD_BITS-1:0] ctx_reg, ctx_next, cty_reg, cty_next;
    logic [D-1:0]       acc_reg, acc_next;
    logic [PT_BITS-1:0] left_reg, left_next, dx_reg, dx_next, dy_reg, dy_next;
    logic [SQ_BITS-1:0] a_reg, a_next, b_reg, b_next;
    logic [D-1:0]       t_reg, t_next;
    logic [RADIUS_BITS-1:0] ry_reg, ry_next;
    logic               mv_reg, mv_next, ml_reg, ml_next;
    logic [PT_BITS-1:0] ox_reg, ox_next, oy_reg, oy_next;
    logic [D-1:0]       od_reg, od_next;
    mul_req_t           req;
    logic [D-1:0]       prod;

    // Unpack the input word
    logic [1:0]             f_mode;
    logic [COORD_BITS-1:0]  f_sx, f_sy, f_ex, f_ey;
    logic [RADIUS_BITS-1:0] f_rx, f_ry;
    assign f_mode = s_tdata[1:0];
    assign f_sx = s_tdata[2 +: COORD_BITS];
    assign f_sy = s_tdata[2+COORD_BITS +: COORD_BITS];
    assign f_ex = s_tdata[2+2*COORD_BITS +: COORD_BITS];
    assign f_ey = s_tdata[2+3*COORD_BITS +: COORD_BITS];
    assign f_rx = s_tdata[2+4*COORD_BITS +: RADIUS_BITS];
    assign f_ry = s_tdata[2+4*COORD_BITS+RADIUS_BITS +: RADIUS_BITS];

    mlce_mul u_mul (.clk(clk), .req(req), .prod(prod));

    logic s_fire;
    assign s_tready = (state_reg == S_IDLE) && !mv_reg;
    assign s_fire   = s_tvalid && s_tready;

    // Working values: a and b zero-extended, x and y sign-extended
    logic [D-1:0] ax, bx, ux, uy, ndx, ndy, ncx, ncy;
    assign ax  = D'(a_reg);
    assign bx  = D'(b_reg);
    assign ux  = D'(signed'(cx_reg));
    assign uy  = D'(signed'(cy_reg));

    // Sequencer: one product a cycle through the shared multiplier
    always_comb
    begin
        state_next = state_reg; act_next = act_reg; mode_next = mode_reg;
        r2_next = r2_reg; cx_next = cx_reg; cy_next = cy_reg;
        ctx_next = ctx_reg; cty_next = cty_reg; acc_next = acc_reg;
        left_next = left_reg; dx_next = dx_reg; dy_next = dy_reg;
        a_next = a_reg; b_next = b_reg; t_next = t_reg; ry_next = ry_reg;
        mv_next = mv_reg; ml_next = ml_reg; ox_next = ox_reg; oy_next = oy_reg;
        od_next = od_reg;
        req.a = '0; req.b = '0;
        ndx = '0; ndy = '0; ncx = '0; ncy = '0;
        if (mv_reg && m_tready)
            mv_next = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (s_fire && s_tuser == CMD_START)
                begin
                    mode_next = f_mode; r2_next = 1'b0;
                    ctx_next = f_sx; cty_next = f_sy; act_next = 1'b0;
                    ry_next = f_ry;
                    unique case (f_mode)
                        MODE_LINE:
                        begin
                            ndx = D'(signed'(f_ex)) - D'(signed'(f_sx));
                            ndy = D'(signed'(f_ey)) - D'(signed'(f_sy));
                            dx_next = ndx[PT_BITS-1:0]; dy_next = ndy[PT_BITS-1:0];
                            cx_next = PT_BITS'(signed'(f_sx));
                            cy_next = PT_BITS'(signed'(f_sy));
                            ncx = D'(signed'(ndy[PT_BITS-1:0]));
                            ncy = D'(signed'(ndx[PT_BITS-1:0]));
                            acc_next = (ncx << 1) - ncy;
                            left_next = ndx[PT_BITS-1:0] + 1'b1;
                            act_next = !ndx[PT_BITS-1];
                        end
                        MODE_CIRCLE:
                        begin
                            cx_next = '0; cy_next = PT_BITS'(f_rx);
                            acc_next = D'(1) - D'(f_rx);
                            act_next = 1'b1;
                        end
                        MODE_ELLIPSE:
                        begin
                            cx_next = '0; cy_next = PT_BITS'(f_ry);
                            req.a = D'(f_rx); req.b = D'(f_rx);
                            state_next = S_E1;
                        end
                        default: ;
                    endcase
                end
                else if (s_fire && act_reg)
                    state_next = S_STEP;
            end
            S_E1:
            begin
                a_next = prod[SQ_BITS-1:0];
                req.a = D'(ry_reg); req.b = D'(ry_reg);
                state_next = S_E2;
            end
            S_E2:
            begin
                b_next = prod[SQ_BITS-1:0];
                req.a = ax; req.b = D'(ry_reg);
                state_next = S_E3;
            end
            S_E3:
            begin
                acc_next = (bx << 2) - (prod << 2) + ax;
                act_next = 1'b1;
                state_next = S_IDLE;
            end
            S_STEP:
            begin
                ox_next = cx_reg; oy_next = cy_reg; od_next = acc_reg; ml_next = 1'b0;
                state_next = S_OUT;
                if (mode_reg == MODE_LINE)
                begin
                    ml_next = (left_reg == PT_BITS'(1));
                    ncx = D'(signed'(dy_reg)) << 1;
                    ncy = D'(signed'(dx_reg)) << 1;
                    if (acc_reg[D-1])
                        acc_next = acc_reg + ncx;
                    else
                    begin
                        acc_next = acc_reg + ncx - ncy;
                        cy_next = cy_reg + 1'b1;
                    end
                    cx_next = cx_reg + 1'b1;
                    left_next = left_reg - 1'b1;
                end
                else
                begin
                    ox_next = cx_reg + PT_BITS'(signed'(ctx_reg));
                    oy_next = cy_reg + PT_BITS'(signed'(cty_reg));
                    if (mode_reg == MODE_CIRCLE)
                    begin
                        cx_next = cx_reg + 1'b1;
                        ncx = D'(signed'(cx_next));
                        if (acc_reg[D-1])
                            acc_next = acc_reg + (ncx << 1) + 1'b1;
                        else
                        begin
                            cy_next = cy_reg - 1'b1;
                            ncy = D'(signed'(cy_next));
                            acc_next = acc_reg + (ncx << 1) + 1'b1 - (ncy << 1);
                        end
                        ml_next = signed'(cx_next) > signed'(cy_next);
                    end
                    else if (r2_reg && signed'(cy_reg) <= 0)
                        ml_next = 1'b1;
                    else
                    begin
                        // Ellipse: first product b*ux
                        req.a = bx; req.b = ux;
                        state_next = S_R1;
                    end
                end
                act_next = act_reg && !ml_next;
            end
            S_R1:
            begin
                t_next = prod;           // b*x
                req.a = ax; req.b = uy;
                state_next = S_R2;
            end
            S_R2:
            begin
                // prod = a*y
                if (!r2_reg)
                begin
                    if (acc_reg[D-1])
                        acc_next = acc_reg + (((t_reg << 1) + 3*bx) << 2);
                    else
                    begin
                        acc_next = acc_reg + (((t_reg << 1) + 3*bx - (prod << 1)
                                              + (ax << 1)) << 2);
                        cy_next = cy_reg - 1'b1;
                    end
                    cx_next = cx_reg + 1'b1;
                    // b*x_new = b*x + b; a*y_new = a*y or a*y - a
                    ndx = t_reg + bx;
                    ndy = acc_reg[D-1] ? prod : prod - ax;
                    if (!(signed'(ndx) < signed'(ndy)))
                    begin
                        r2_next = 1'b1;
                        ncx = (D'(signed'(cx_next)) << 1) + 1'b1;
                        t_next = ncx;
                        req.a = ncx; req.b = ncx;
                        state_next = S_R3;
                    end
                    else
                        state_next = S_OUT;
                end
                else
                begin
                    if (acc_reg[D-1])
                    begin
                        acc_next = acc_reg + (((t_reg << 1) + (bx << 1) - (prod << 1)
                                              + 3*ax) << 2);
                        cx_next = cx_reg + 1'b1;
                    end
                    else
                        acc_next = acc_reg + ((3*ax - (prod << 1)) << 2);
                    cy_next = cy_reg - 1'b1;
                    state_next = S_OUT;
                end
            end
            S_R3:
            begin
                t_next = prod;           // tx^2
                req.a = prod; req.b = bx;
                state_next = S_R4;
            end
            S_R4:
            begin
                acc_next = prod;         // b*tx^2
                // Square the magnitude of y-1 so the narrow multiplier sees it positive
                ncy = uy - 1'b1;
                if (ncy[D-1])
                    ncy = -ncy;
                t_next = ncy;
                req.a = ncy; req.b = ncy;
                state_next = S_R5;
            end
            S_R5:
            begin
                t_next = prod;           // ty^2
                req.a = prod; req.b = ax;
                state_next = S_E4;
            end
            S_E4:
            begin
                acc_next = acc_reg + (prod << 2);
                req.a = ax; req.b = bx;
                state_next = S_E5;
            end
            S_E5:
            begin
                acc_next = acc_reg - (prod << 2);
                state_next = S_OUT;
            end
            S_OUT:
            begin
                mv_next = 1'b1;
                state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    // Hold state and the output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE; act_reg <= 1'b0; mv_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next; act_reg <= act_next; mv_reg <= mv_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mode_reg <= mode_next; r2_reg <= r2_next; cx_reg <= cx_next;
        cy_reg <= cy_next; ctx_reg <= ctx_next; cty_reg <= cty_next;
        acc_reg <= acc_next; left_reg <= left_next; dx_reg <= dx_next;
        dy_reg <= dy_next; a_reg <= a_next; b_reg <= b_next; t_reg <= t_next;
        ry_reg <= ry_next; ml_reg <= ml_next; ox_reg <= ox_next;
        oy_reg <= oy_next; od_reg <= od_next;
    end

    assign m_tvalid = mv_reg;
    assign m_tlast  = ml_reg;
    assign m_tdata  = {(OUT_BYTES*8-OUT_BITS)'(0), od_reg, oy_reg, ox_reg};
endmodule
`default_nettype wire

/* rtl/mlce_checker.sv */
// Port-level checker for the rasteriser, bound to the top level
`default_nettype none
`include "assert_macros.svh"
module mlce_checker (
    input wire logic clk,
    input wire logic rst_n,
    input wire logic s_tvalid,
    input wire logic s_tready,
    input wire logic m_tvalid,
    input wire logic m_tready,
    input wire logic m_tlast
);
    `CHK_ASSERT(no_take_while_pending, clk, rst_n, m_tvalid |-> !s_tready, "input taken while output pending")
    `CHK_ASSERT(out_holds, clk, rst_n, m_tvalid && !m_tready |=> m_tvalid, "output word dropped")
    `CHK_ASSERT(last_holds, clk, rst_n, m_tvalid && !m_tready |=> $stable(m_tlast), "tlast changed under stall")
    `CHK_ASSERT(ready_after_out, clk, rst_n, m_tvalid && m_tready |=> !m_tvalid, "output repeated")
    `CHK_ASSERT(in_held, clk, rst_n, s_tvalid && !s_tready |=> s_tvalid, "input word withdrawn")
endmodule
bind midpoint_line_circle_ellipse_raster mlce_checker u_chk (
    .clk(clk), .rst_n(rst_n), .s_tvalid(s_tvalid), .s_tready(s_tready),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tlast(m_tlast));
`default_nettype wire

/* dv/tb.sv */
// Self-checking testbench for the midpoint line, circle and ellipse rasteriser
`default_nettype none
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import mlce_pkg::*;

    typedef struct packed {
        logic                    command;
        logic [1:0]              shape;
        logic [COORD_BITS-1:0]   sx;
        logic [COORD_BITS-1:0]   sy;
        logic [COORD_BITS-1:0]   ex;
        logic [COORD_BITS-1:0]   ey;
        logic [RADIUS_BITS-1:0]  rx;
        logic [RADIUS_BITS-1:0]  ry;
    } cmd_t;

    typedef struct packed {
        logic [PT_BITS-1:0]  px;
        logic [PT_BITS-1:0]  py;
        logic [DEC_BITS-1:0] dv;
        logic                last;
    } point_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [IN_BYTES*8-1:0] s_tdata = '0;
    logic s_tuser = 1'b0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [OUT_BYTES*8-1:0] m_tdata;
    logic m_tlast;

    cmd_t   pending_cmds[$];
    point_t expected_points[$];
    int     errors = 0;
    int     points_seen = 0;
    int     cmds_sent = 0;
    int     send_idle_pct = 35;
    int     take_idle_pct = 71;
    bit     hold_send = 1'b0;
    longint cycles = 0;

    // rasteriser state mirror
    bit              busy;
    logic [1:0]      shp;
    bit              reg2;
    logic signed [PT_BITS-1:0]  cx, cy, dlx, dly;
    logic signed [COORD_BITS-1:0] ctrx, ctry;
    logic signed [DEC_BITS-1:0] dacc;
    logic [PT_BITS-1:0]   left;
    logic [SQ_BITS-1:0]   asq, bsq;

    always #1 clk = ~clk;

    midpoint_line_circle_ellipse_raster uut (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast)
    );

    // Advance the rasteriser mirror by one command, queueing any point it emits
    task automatic rasterise(input cmd_t c);
        logic signed [DEC_BITS-1:0] a, b, ux, uy, tx, ty, pd;
        logic signed [PT_BITS-1:0] px, py;
        logic signed [PT_BITS-1:0] sx, sy;
        bit lst;
        sx = PT_BITS'($signed(c.sx));
        sy = PT_BITS'($signed(c.sy));
        lst = 1'b0;
        if (c.command == CMD_START) begin
            shp = c.shape;
            reg2 = 1'b0;
            ctrx = c.sx;
            ctry = c.sy;
            busy = 1'b0;
            if (shp == MODE_LINE) begin
                dlx = PT_BITS'($signed(c.ex)) - sx;
                dly = PT_BITS'($signed(c.ey)) - sy;
                cx = sx;
                cy = sy;
                dacc = 2 * DEC_BITS'(dly) - DEC_BITS'(dlx);
                if (dlx >= 0) begin
                    left = dlx + 1;
                    busy = 1'b1;
                end
            end else if (shp == MODE_CIRCLE) begin
                cx = '0;
                cy = PT_BITS'(c.rx);
                dacc = 1 - DEC_BITS'(c.rx);
                busy = 1'b1;
            end else if (shp == MODE_ELLIPSE) begin
                asq = c.rx * c.rx;
                bsq = c.ry * c.ry;
                cx = '0;
                cy = PT_BITS'(c.ry);
                dacc = 4 * DEC_BITS'(bsq) - 4 * DEC_BITS'(asq) * DEC_BITS'(c.ry)
                       + DEC_BITS'(asq);
                busy = 1'b1;
            end
            return;
        end
        if (!busy)
            return;
        pd = dacc;
        a = DEC_BITS'(asq);
        b = DEC_BITS'(bsq);
        if (shp == MODE_LINE) begin
            px = cx;
            py = cy;
            lst = (left == 1);
            if (dacc < 0)
                dacc = dacc + 2 * DEC_BITS'(dly);
            else begin
                dacc = dacc + 2 * DEC_BITS'(dly) - 2 * DEC_BITS'(dlx);
                cy = cy + 1;
            end
            cx = cx + 1;
            left = left - 1;
        end else if (shp == MODE_CIRCLE) begin
            px = cx + PT_BITS'(ctrx);
            py = cy + PT_BITS'(ctry);
            cx = cx + 1;
            if (dacc < 0)
                dacc = dacc + 2 * DEC_BITS'(cx) + 1;
            else begin
                cy = cy - 1;
                dacc = dacc + 2 * DEC_BITS'(cx) + 1 - 2 * DEC_BITS'(cy);
            end
            lst = (cx > cy);
        end else begin
            ux = DEC_BITS'(cx);
            uy = DEC_BITS'(cy);
            px = cx + PT_BITS'(ctrx);
            py = cy + PT_BITS'(ctry);
            if (!reg2) begin
                if (dacc < 0)
                    dacc = dacc + 4 * (2 * b * ux + 3 * b);
                else begin
                    dacc = dacc + 4 * (2 * b * ux + 3 * b - 2 * a * uy + 2 * a);
                    cy = cy - 1;
                end
                cx = cx + 1;
                if (!(2 * b * DEC_BITS'(cx) < 2 * a * DEC_BITS'(cy))) begin
                    reg2 = 1'b1;
                    tx = 2 * DEC_BITS'(cx) + 1;
                    ty = DEC_BITS'(cy) - 1;
                    dacc = b * tx * tx + 4 * a * ty * ty - 4 * a * b;
                end
            end else if (cy <= 0)
                lst = 1'b1;
            else begin
                if (dacc < 0) begin
                    dacc = dacc + 4 * (2 * b * ux + 2 * b - 2 * a * uy + 3 * a);
                    cx = cx + 1;
                end else
                    dacc = dacc + 4 * (3 * a - 2 * a * uy);
                cy = cy - 1;
            end
        end
        if (lst)
            busy = 1'b0;
        expected_points.push_back('{px, py, pd, lst});
    endtask

    // Drive command words from the pending queue
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                rasterise(pending_cmds.pop_front());
                cmds_sent++;
            end
            if ((!s_tvalid || s_tready) ) begin
                if (pending_cmds.size() > 0 && !hold_send
                    && ($urandom_range(99) >= send_idle_pct
                        || (s_tvalid && s_tready && 0))) begin
                    s_tvalid <= 1'b1;
                    s_tuser  <= pending_cmds[0].command;
                    s_tdata  <= (IN_BYTES*8)'({pending_cmds[0].ry, pending_cmds[0].rx,
                                 pending_cmds[0].ey, pending_cmds[0].ex, pending_cmds[0].sy,
                                 pending_cmds[0].sx, pending_cmds[0].shape});
                end else
                    s_tvalid <= 1'b0;
            end
        end
    end

    // Take result words and check against the oldest expected point
    always @(posedge clk or negedge rst_n) begin
        point_t got, want;
        if (!rst_n) begin
            m_tready <= 1'b0;
        end else begin
            cycles++;
            if (m_tvalid && m_tready) begin
                got = '{m_tdata[PT_BITS-1:0], m_tdata[2*PT_BITS-1:PT_BITS],
                        m_tdata[2*PT_BITS+DEC_BITS-1:2*PT_BITS], m_tlast};
                points_seen++;
                if (expected_points.size() == 0) begin
                    $error("unexpected point word x=%0h y=%0h", got.px, got.py);
                    errors++;
                end else begin
                    want = expected_points.pop_front();
                    if (got.px !== want.px) begin
                        $error("point_x expected %0h got %0h", want.px, got.px); errors++;
                    end
                    if (got.py !== want.py) begin
                        $error("point_y expected %0h got %0h", want.py, got.py); errors++;
                    end
                    if (got.dv !== want.dv) begin
                        $error("decision expected %0h got %0h", want.dv, got.dv); errors++;
                    end
                    if (got.last !== want.last) begin
                        $error("last_point expected %0b got %0b", want.last, got.last);
                        errors++;
                    end
                end
            end
            m_tready <= ($urandom_range(99) >= take_idle_pct);
            if (cycles > 3000000) begin
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

    function automatic cmd_t start_cmd(logic [1:0] s, int sx, int sy, int ex, int ey,
                                        int rx, int ry);
        start_cmd = '{CMD_START, s, sx[11:0], sy[11:0], ex[11:0], ey[11:0],
                      rx[9:0], ry[9:0]};
    endfunction

    function automatic cmd_t next_cmd();
        next_cmd = '{CMD_NEXT, 2'($urandom), 12'($urandom), 12'($urandom), 12'($urandom),
                     12'($urandom), 10'($urandom), 10'($urandom)};
    endfunction

    // Queue a start plus the given number of next commands
    task automatic add_shape(input cmd_t s, input int steps);
        pending_cmds.push_back(s);
        repeat (steps) pending_cmds.push_back(next_cmd());
    endtask

    task automatic wait_drained();
        while (pending_cmds.size() > 0 || s_tvalid || expected_points.size() > 0)
            @(posedge clk);
    endtask

    task automatic random_phase(input int n);
        int k, ln, r, rr, st;
        cmd_t c;
        k = 0;
        while (k < n) begin
            c = next_cmd();
            c.command = CMD_START;
            r = $urandom_range(99);
            c.shape = (r < 3) ? MODE_UNUSED : 2'($urandom_range(2));
            ln = $urandom_range(15);
            if ($urandom_range(9) == 0) ln = $urandom_range(60);
            rr = $urandom_range(1, 12);
            if ($urandom_range(19) == 0) rr = $urandom_range(1, 1023);
            c.rx = rr[9:0];
            c.ry = 10'($urandom_range(1, 12));
            if (c.shape == MODE_LINE && $urandom_range(3) != 0) begin
                c.ex = c.sx + 12'(ln);
                c.ey = c.sy + 12'($urandom_range(ln));
            end
            st = ln + 2 * rr + 2 * c.ry + 2;
            if ($urandom_range(7) == 0) st = $urandom_range(8);
            if (st > 80) st = 80;
            add_shape(c, st);
            k += st + 1;
            while (pending_cmds.size() > 40) @(posedge clk);
        end
        wait_drained();
    endtask

    initial begin
        busy = 0; shp = 0; reg2 = 0; cx = 0; cy = 0; ctrx = 0; ctry = 0;
        dacc = 0; left = 0; dlx = 0; dly = 0; asq = 0; bsq = 0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        // Directed: idle next, extremes, every shape, abort, unused code, zero radii
        pending_cmds.push_back(next_cmd());
        add_shape(start_cmd(MODE_LINE, -2048, -2048, -2045, -2046, 1, 1), 5);
        add_shape(start_cmd(MODE_LINE, 2047, 2047, -2048, 0, 1, 1), 2);
        add_shape(start_cmd(MODE_LINE, -2048, 5, 2047, 2047, 1, 1), 3);
        add_shape(start_cmd(MODE_CIRCLE, 2047, -2048, 0, 0, 3, 1), 4);
        add_shape(start_cmd(MODE_ELLIPSE, -5, 7, 0, 0, 3, 2), 9);
        add_shape(start_cmd(MODE_ELLIPSE, 0, 0, 0, 0, 1023, 1023), 3);
        add_shape(start_cmd(MODE_ELLIPSE, 1, 1, 0, 0, 0, 0), 3);
        add_shape(start_cmd(MODE_CIRCLE, 0, 0, 0, 0, 0, 0), 2);
        add_shape(start_cmd(MODE_UNUSED, 0, 0, 0, 0, 1, 1), 1);
        wait_drained();
        // Sender is held off with hold_send after every expected point has arrived
        hold_send = 1'b1;
        repeat (20) @(posedge clk);
        hold_send = 1'b0;
        random_phase(600);
        send_idle_pct = 71;
        take_idle_pct = 35;
        random_phase(550);
        send_idle_pct = 0;
        take_idle_pct = 0;
        random_phase(550);
        repeat (40) @(posedge clk);
        if (expected_points.size() != 0) begin
            $error("%0d expected points never arrived", expected_points.size());
            errors++;
        end
        $display("Sent %0d commands across lines, circles and ellipses; checked %0d points.",
                 cmds_sent, points_seen);
        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end
endmodule
`default_nettype wire
